// ===== sv/slru_pkg.sv =====
package slru_pkg;

   // Access kinds carried in the request.
   localparam logic [1:0] KIND_MODIFY = 2'd2;
   localparam logic [1:0] KIND_FETCH  = 2'd3;

   // Configuration register indexes and port widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd2;

   localparam logic [2:0] SET_BITS_RESET   = 3'd4;
   localparam logic [5:0] BLOCK_BITS_RESET = 6'd4;
   localparam logic [3:0] WAYS_USED_RESET  = 4'd8;
   localparam logic [5:0] BLOCK_BITS_MAX   = 6'd57;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
   } slru_req_type;

   typedef struct packed {
      logic        was_hit;
      logic        evicted;
      logic        last;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] eviction_count;
   } slru_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_INDEX,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE,
      ST_WRITE
   } slru_state_type;

   // Sequencer commands to the way scanner.
   typedef struct packed {
      logic start;
      logic step;
   } slru_scan_ctl_type;

   // Scanner status back to the sequencer.
   typedef struct packed {
      logic last;
      logic hit;
      logic empty;
   } slru_scan_stat_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
   endfunction

endpackage

// ===== sv/slru_row_store.sv =====
module slru_row_store
   import slru_pkg::*;
#(
   parameter int SET_W = 6,
   parameter int WAYS  = 8,
   parameter int TAG_W = 62,
   parameter int AGE_W = 3
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [SET_W-1:0]            rd_set,
   output logic [WAYS-1:0][TAG_W-1:0]  rd_tag,
   output logic [WAYS-1:0][AGE_W-1:0]  rd_age,
   output logic [WAYS-1:0]             rd_valid,
   input  logic                        wr_en,
   input  logic [SET_W-1:0]            wr_set,
   input  logic [WAYS-1:0][TAG_W-1:0]  wr_tag,
   input  logic [WAYS-1:0][AGE_W-1:0]  wr_age,
   input  logic [WAYS-1:0]             wr_valid
);

   localparam int NUM_SETS = 1 << SET_W;

   logic [WAYS-1:0][TAG_W-1:0] tag_mem [NUM_SETS];
   logic [WAYS-1:0][AGE_W-1:0] age_mem [NUM_SETS];
   logic [WAYS-1:0]            valid_mem [NUM_SETS];

   // One flag per set: a set never written reads as empty with all ages zero.
   logic [NUM_SETS-1:0]        init_ff;
   logic                       rd_init_ff;
   logic [WAYS-1:0][TAG_W-1:0] rd_tag_ff;
   logic [WAYS-1:0][AGE_W-1:0] rd_age_ff;
   logic [WAYS-1:0]            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_set]   <= wr_tag;
         age_mem[wr_set]   <= wr_age;
         valid_mem[wr_set] <= wr_valid;
      end
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_set];
         rd_age_ff   <= age_mem[rd_set];
         rd_valid_ff <= valid_mem[rd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= '0;
         rd_init_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            init_ff[wr_set] <= 1'b1;
         end
         if (rd_en) begin
            rd_init_ff <= init_ff[rd_set];
         end
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_age   = rd_init_ff ? rd_age_ff : '0;
   assign rd_valid = rd_init_ff ? rd_valid_ff : '0;

endmodule

// ===== sv/slru_way_scan.sv =====
module slru_way_scan
   import slru_pkg::*;
#(
   parameter int WAYS   = 8,
   parameter int TAG_W  = 62,
   parameter int AGE_W  = 3,
   parameter int WIDX_W = 3,
   parameter int CNT_W  = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  slru_scan_ctl_type           ctl,
   input  logic [CNT_W-1:0]            ways_n,
   input  logic [TAG_W-1:0]            key_tag,
   input  logic [WAYS-1:0][TAG_W-1:0]  row_tag,
   input  logic [WAYS-1:0][AGE_W-1:0]  row_age,
   input  logic [WAYS-1:0]             row_valid,
   output slru_scan_stat_type          stat,
   output logic [WIDX_W-1:0]           hit_way,
   output logic [WIDX_W-1:0]           empty_way,
   output logic [WIDX_W-1:0]           victim_way
);

   logic [CNT_W-1:0]  cnt_ff;
   logic              hit_ff;
   logic              empty_ff;
   logic [WIDX_W-1:0] hit_way_ff;
   logic [WIDX_W-1:0] empty_way_ff;
   logic [WIDX_W-1:0] victim_ff;
   logic [AGE_W-1:0]  victim_age_ff;
   logic [WIDX_W-1:0] idx;
   logic              match;

   // One way is examined per step by a single tag comparator.
   assign idx   = cnt_ff[WIDX_W-1:0];
   assign match = row_valid[idx] && (row_tag[idx] == key_tag);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else if (ctl.start) begin
         cnt_ff   <= '0;
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else if (ctl.step) begin
         cnt_ff <= CNT_W'(cnt_ff + 1'b1);
         if (match && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!row_valid[idx] && !empty_ff) begin
            empty_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         victim_ff     <= '0;
         victim_age_ff <= '0;
      end else if (ctl.step) begin
         if (match && !hit_ff) begin
            hit_way_ff <= idx;
         end
         if (!row_valid[idx] && !empty_ff) begin
            empty_way_ff <= idx;
         end
         if (row_age[idx] > victim_age_ff) begin
            victim_ff     <= idx;
            victim_age_ff <= row_age[idx];
         end
      end
   end

   assign stat.last  = (CNT_W'(cnt_ff + 1'b1) == ways_n);
   assign stat.hit   = hit_ff;
   assign stat.empty = empty_ff;
   assign hit_way    = hit_way_ff;
   assign empty_way  = empty_way_ff;
   assign victim_way = victim_ff;

endmodule

// ===== sv/set_assoc_lru_cache_sim.sv =====
// Set-associative cache simulator with true LRU replacement. Each request
// transfer carries one trace access (load, store, modify or instruction
// fetch) and an address; each data access yields one response transfer
// telling whether it hit and whether a valid line was evicted, together with
// the running, saturating hit, miss and eviction totals. A modify produces
// two responses, the second marked last, and an instruction fetch produces
// none and is taken while the sequencer stays idle. The address is split
// by the block_bits and set_bits registers, clamped to their legal ranges,
// and only the first ways_used ways of a set take part. A load or store
// occupies the block while a single tag comparator walks the ways of the
// selected set one per cycle, between a registered read and a write-back of
// the whole set row; a modify walks them twice before its write-back. The
// next request is taken as soon as the row is written back, even while the
// last response still waits in the output register. No clearing pass is
// needed after reset: a per-set flag makes never-written sets read as empty.
module set_assoc_lru_cache_sim
   import slru_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int WAYS         = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  slru_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output slru_rsp_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SET_W  = MAX_SET_BITS;
   localparam int TAG_W  = ADDR_WIDTH - 2;
   localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int CNT_W  = $clog2(WAYS + 1);
   localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

   // Configuration registers.
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RESET;
         block_bits_ff <= BLOCK_BITS_RESET;
         ways_used_ff  <= WAYS_USED_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            CSR_WAYS_USED:  ways_used_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Clamped working values of the registers.
   logic [SB_W-1:0]  sb_eff;
   logic [5:0]       bb_eff;
   logic [CNT_W-1:0] nw_eff;

   always_comb begin
      if (set_bits_ff == 3'd0) begin
         sb_eff = SB_W'(1);
      end else if (set_bits_ff > MAX_SET_BITS) begin
         sb_eff = SB_W'(MAX_SET_BITS);
      end else begin
         sb_eff = SB_W'(set_bits_ff);
      end
      if (block_bits_ff == 6'd0) begin
         bb_eff = 6'd1;
      end else if (block_bits_ff > BLOCK_BITS_MAX) begin
         bb_eff = BLOCK_BITS_MAX;
      end else begin
         bb_eff = block_bits_ff;
      end
      if (ways_used_ff == 4'd0) begin
         nw_eff = CNT_W'(1);
      end else if (ways_used_ff > WAYS) begin
         nw_eff = CNT_W'(WAYS);
      end else begin
         nw_eff = CNT_W'(ways_used_ff);
      end
   end

   // Sequencer.
   slru_state_type     state_ff;
   slru_state_type     state_in;
   slru_scan_ctl_type  scan_ctl;
   slru_scan_stat_type scan_stat;
   logic               take_req;
   logic               mem_rd;
   logic               mem_wr;
   logic               do_update;
   logic               slot_free;
   logic               first_of_modify;

   logic [1:0]            kind_ff;
   logic                  pass_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [ADDR_WIDTH-1:0] shifted_ff;
   logic [SET_W-1:0]      set_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic                  rsp_valid_ff;
   slru_rsp_type          rsp_data_ff;

   assign slot_free       = !rsp_valid_ff || rsp_ready;
   assign first_of_modify = (kind_ff == KIND_MODIFY) && !pass_ff;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      take_req       = 1'b0;
      scan_ctl.start = 1'b0;
      scan_ctl.step  = 1'b0;
      mem_rd         = 1'b0;
      mem_wr         = 1'b0;
      do_update      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               take_req = 1'b1;
               if (req_data.kind != KIND_FETCH) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: state_in = ST_INDEX;
         ST_INDEX: state_in = ST_READ;
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            scan_ctl.start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            scan_ctl.step = 1'b1;
            if (scan_stat.last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (slot_free) begin
               do_update = 1'b1;
               if (first_of_modify) begin
                  scan_ctl.start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            mem_wr   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Address split: the block offset is shifted out first, then the set
   // index is masked off and the remainder becomes the tag.
   always_ff @(posedge clock) begin
      if (take_req) begin
         kind_ff <= req_data.kind;
         addr_ff <= req_data.address[ADDR_WIDTH-1:0];
      end
      if (state_ff == ST_SHIFT) begin
         shifted_ff <= addr_ff >> bb_eff;
      end
      if (state_ff == ST_INDEX) begin
         set_ff <= shifted_ff[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
         tag_ff <= TAG_W'(shifted_ff >> sb_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
      end else if (take_req) begin
         pass_ff <= 1'b0;
      end else if (do_update) begin
         pass_ff <= 1'b1;
      end
   end

   // Row storage and the working copy of the selected set.
   logic [WAYS-1:0][TAG_W-1:0] mem_tag;
   logic [WAYS-1:0][AGE_W-1:0] mem_age;
   logic [WAYS-1:0]            mem_valid;
   logic [WAYS-1:0][TAG_W-1:0] row_tag_ff;
   logic [WAYS-1:0][AGE_W-1:0] row_age_ff;
   logic [WAYS-1:0]            row_valid_ff;
   logic [WAYS-1:0][TAG_W-1:0] row_tag_in;
   logic [WAYS-1:0][AGE_W-1:0] row_age_in;
   logic [WAYS-1:0]            row_valid_in;

   slru_row_store #(
      .SET_W (SET_W),
      .WAYS  (WAYS),
      .TAG_W (TAG_W),
      .AGE_W (AGE_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (mem_rd),
      .rd_set   (set_ff),
      .rd_tag   (mem_tag),
      .rd_age   (mem_age),
      .rd_valid (mem_valid),
      .wr_en    (mem_wr),
      .wr_set   (set_ff),
      .wr_tag   (row_tag_ff),
      .wr_age   (row_age_ff),
      .wr_valid (row_valid_ff)
   );

   logic [WIDX_W-1:0] hit_way;
   logic [WIDX_W-1:0] empty_way;
   logic [WIDX_W-1:0] victim_way;

   slru_way_scan #(
      .WAYS   (WAYS),
      .TAG_W  (TAG_W),
      .AGE_W  (AGE_W),
      .WIDX_W (WIDX_W),
      .CNT_W  (CNT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .ways_n     (nw_eff),
      .key_tag    (tag_ff),
      .row_tag    (row_tag_ff),
      .row_age    (row_age_ff),
      .row_valid  (row_valid_ff),
      .stat       (scan_stat),
      .hit_way    (hit_way),
      .empty_way  (empty_way),
      .victim_way (victim_way)
   );

   // Touch of the chosen way. A hit touches the matching way, a miss fills
   // the first empty way (treated as oldest beforehand), and otherwise the
   // oldest way is replaced. Every other valid way in use that was younger
   // than the touched way ages by one, saturating at the oldest age.
   logic [WIDX_W-1:0] touch_way;
   logic [AGE_W-1:0]  old_age;
   logic              is_evict;

   always_comb begin
      is_evict = !scan_stat.hit && !scan_stat.empty;
      if (scan_stat.hit) begin
         touch_way = hit_way;
         old_age   = row_age_ff[hit_way];
      end else if (scan_stat.empty) begin
         touch_way = empty_way;
         old_age   = AGE_OLDEST;
      end else begin
         touch_way = victim_way;
         old_age   = row_age_ff[victim_way];
      end
      row_tag_in   = row_tag_ff;
      row_valid_in = row_valid_ff;
      row_age_in   = row_age_ff;
      for (int i = 0; i < WAYS; i++) begin
         if (WIDX_W'(i) == touch_way) begin
            row_age_in[i] = '0;
            if (!scan_stat.hit) begin
               row_tag_in[i]   = tag_ff;
               row_valid_in[i] = 1'b1;
            end
         end else if ((CNT_W'(i) < nw_eff) && row_valid_ff[i] &&
                      (row_age_ff[i] < old_age) && (row_age_ff[i] < AGE_OLDEST)) begin
            row_age_in[i] = AGE_W'(row_age_ff[i] + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         row_tag_ff   <= mem_tag;
         row_age_ff   <= mem_age;
         row_valid_ff <= mem_valid;
      end else if (do_update) begin
         row_tag_ff   <= row_tag_in;
         row_age_ff   <= row_age_in;
         row_valid_ff <= row_valid_in;
      end
   end

   // Running totals and the response register. The register frees the
   // sequencer to accept the next request while a response transfer waits.
   logic [31:0]  hits_ff;
   logic [31:0]  misses_ff;
   logic [31:0]  evictions_ff;
   slru_rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.was_hit        = scan_stat.hit;
      rsp_data_in.evicted        = is_evict;
      rsp_data_in.last           = !first_of_modify;
      rsp_data_in.hit_count      = scan_stat.hit ? sat_inc(hits_ff) : hits_ff;
      rsp_data_in.miss_count     = scan_stat.hit ? misses_ff : sat_inc(misses_ff);
      rsp_data_in.eviction_count = is_evict ? sat_inc(evictions_ff) : evictions_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         evictions_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_update) begin
            hits_ff      <= rsp_data_in.hit_count;
            misses_ff    <= rsp_data_in.miss_count;
            evictions_ff <= rsp_data_in.eviction_count;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_update) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/tb_set_assoc_lru_cache_sim.sv =====
module tb_set_assoc_lru_cache_sim;
   timeunit 1ns;
   timeprecision 1ps;
   import slru_pkg::*;

   // Access kinds that the package leaves unnamed, and the spare register
   // index, which the block must ignore.
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int SETS   = 64;
   localparam int WAYS   = 8;
   localparam int MAX_SB = 6;
   localparam int MAX_BB = 57;

   // Quiet cycles after the last expected response before a register write
   // or the end of the run. The block has written its row back by the time it
   // hands over the last response, so this leaves ample margin.
   localparam int TAIL = 40;
   // Cycle limit after which the watchdog ends the run as a failure.
   localparam int unsigned LIMIT = 1_000_000;

   typedef struct packed {
      logic [1:0]   kind;
      logic [63:0]  address;
      logic         typed;
      logic [1:0]   n_typed;
      slru_rsp_type r0;
      slru_rsp_type r1;
   } probe_row_type;

   localparam slru_rsp_type NO_RSP = '0;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   // Directed probes, run with the geometry that reset leaves (16 sets of
   // 8 ways, 16-byte blocks). Where the outcome is obvious it is written out;
   // the rest are checked against the cache model below. Set 0 is filled,
   // one of its middle-aged ways is touched, and then it is made to evict
   // several times so that the victim choice is exercised.
   localparam probe_row_type PROBES [21] = '{
      '{KIND_LOAD,  64'h0, 1'b1, 2'd1,
        '{1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0}, NO_RSP},
      '{KIND_LOAD,  64'hF, 1'b1, 2'd1,
        '{1'b1, 1'b0, 1'b1, 32'd1, 32'd1, 32'd0}, NO_RSP},
      '{KIND_FETCH, 64'h0, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{KIND_STORE, ALL_ONES, 1'b1, 2'd1,
        '{1'b0, 1'b0, 1'b1, 32'd1, 32'd2, 32'd0}, NO_RSP},
      '{KIND_MODIFY, ALL_ONES, 1'b1, 2'd2,
        '{1'b1, 1'b0, 1'b0, 32'd2, 32'd2, 32'd0},
        '{1'b1, 1'b0, 1'b1, 32'd3, 32'd2, 32'd0}},
      '{KIND_MODIFY, 64'h100, 1'b1, 2'd2,
        '{1'b0, 1'b0, 1'b0, 32'd3, 32'd3, 32'd0},
        '{1'b1, 1'b0, 1'b1, 32'd4, 32'd3, 32'd0}},
      '{KIND_FETCH, ALL_ONES, 1'b1, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h200, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h300, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h400, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_STORE, 64'h500, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h600, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_STORE, 64'h700, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h308, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_STORE, 64'h800, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_MODIFY, 64'h0, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h100, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_STORE, 64'hFFFF_FFFF_FFFF_FF0F, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_LOAD,  64'h8000_0000_0000_0000, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_FETCH, 64'h5555_5555_5555_5555, 1'b0, 2'd0, NO_RSP, NO_RSP},
      '{KIND_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 2'd0, NO_RSP, NO_RSP}
   };

   // Random phases. Phase 0 keeps the reset geometry; a negative set_bits
   // entry means the geometry is drawn at random. Some phases write values
   // outside the legal ranges so that the clamping is exercised.
   localparam int N_PHASES = 9;
   localparam int PH_SB    [N_PHASES] = '{4, 1,  6, 0,  7, 2, 3, -1, -1};
   localparam int PH_BB    [N_PHASES] = '{4, 1, 57, 0, 63, 3, 6,  0,  0};
   localparam int PH_NW    [N_PHASES] = '{8, 1,  8, 0, 15, 4, 2,  0,  0};
   localparam int PH_ITEMS [N_PHASES] = '{150, 150, 150, 100, 150, 150, 150, 75, 75};

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   slru_req_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   slru_rsp_type          rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   set_assoc_lru_cache_sim dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5ns clock = ~clock;

   // Cache model state: our own copy of the valid bits, tags and LRU ages,
   // the running totals and the three geometry registers.
   bit          line_ok    [SETS][WAYS];
   logic [63:0] line_tag_m [SETS][WAYS];
   logic [2:0]  line_lru   [SETS][WAYS];
   logic [31:0] hits_m;
   logic [31:0] misses_m;
   logic [31:0] evicts_m;
   logic [2:0]  cfg_sb;
   logic [5:0]  cfg_bb;
   logic [3:0]  cfg_nw;

   // Responses that the accepted requests must still produce, oldest first.
   slru_rsp_type rsp_due [$];
   // Recently used addresses, replayed now and then so that hits occur.
   logic [63:0]  recent_addr [$];

   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;
   int unsigned rsp_hold    = 0;
   // When set, neither side idles, so back-to-back transfers are covered.
   bit          calm        = 1'b0;

   // The registers hold any value their width allows; the block clamps them
   // to the legal range only when it uses them.
   function automatic int eff_sb();
      int v;
      v = cfg_sb;
      if (v < 1) v = 1;
      if (v > MAX_SB) v = MAX_SB;
      return v;
   endfunction

   function automatic int eff_bb();
      int v;
      v = cfg_bb;
      if (v < 1) v = 1;
      if (v > MAX_BB) v = MAX_BB;
      return v;
   endfunction

   function automatic int eff_nw();
      int v;
      v = cfg_nw;
      if (v < 1) v = 1;
      if (v > WAYS) v = WAYS;
      return v;
   endfunction

   function automatic logic [31:0] count_up(input logic [31:0] v);
      return v + {31'd0, v != CNT_MAX};
   endfunction

   task automatic clear_model();
      int s;
      int w;
      for (s = 0; s < SETS; s++) begin
         for (w = 0; w < WAYS; w++) begin
            line_ok[s][w]    = 1'b0;
            line_tag_m[s][w] = '0;
            line_lru[s][w]   = '0;
         end
      end
      hits_m   = '0;
      misses_m = '0;
      evicts_m = '0;
      cfg_sb   = SET_BITS_RESET;
      cfg_bb   = BLOCK_BITS_RESET;
      cfg_nw   = WAYS_USED_RESET;
   endtask

   // Make way w the most recently used. Every other valid way in use that was
   // younger than w's old age grows one older, saturating at the oldest age.
   task automatic promote_way(input int s, input int n, input int w,
                              input logic [2:0] old_age);
      int i;
      for (i = 0; i < n; i++) begin
         if (i != w && line_ok[s][i] && line_lru[s][i] < old_age &&
             line_lru[s][i] != 3'(WAYS - 1)) begin
            line_lru[s][i] = line_lru[s][i] + 3'd1;
         end
      end
      line_lru[s][w] = '0;
   endtask

   // One data access: look the tag up among the ways in use, fill the first
   // empty way on a miss, or else replace the oldest way (lowest index on a
   // tie). Returns the response that the block must give for it.
   task automatic cache_access(input logic [63:0] addr, input bit is_last,
                               output slru_rsp_type r);
      int          sb;
      int          bb;
      int          n;
      int          s;
      int          i;
      int          w;
      bit          hit;
      bit          placed;
      bit          spilled;
      logic [63:0] tag;
      sb      = eff_sb();
      bb      = eff_bb();
      n       = eff_nw();
      s       = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
      tag     = (addr >> bb) >> sb;
      hit     = 1'b0;
      placed  = 1'b0;
      spilled = 1'b0;
      for (i = 0; i < n; i++) begin
         if (!hit && line_ok[s][i] && line_tag_m[s][i] == tag) begin
            hit = 1'b1;
            promote_way(s, n, i, line_lru[s][i]);
         end
      end
      if (hit) begin
         hits_m = count_up(hits_m);
      end else begin
         misses_m = count_up(misses_m);
         for (i = 0; i < n; i++) begin
            if (!placed && !line_ok[s][i]) begin
               placed           = 1'b1;
               line_ok[s][i]    = 1'b1;
               line_tag_m[s][i] = tag;
               // A freshly filled way counts as the oldest before the touch.
               promote_way(s, n, i, 3'(WAYS - 1));
            end
         end
         if (!placed) begin
            spilled  = 1'b1;
            evicts_m = count_up(evicts_m);
            w = 0;
            for (i = 1; i < n; i++) begin
               if (line_lru[s][i] > line_lru[s][w]) w = i;
            end
            line_tag_m[s][w] = tag;
            promote_way(s, n, w, line_lru[s][w]);
         end
      end
      r.was_hit        = hit;
      r.evicted        = spilled;
      r.last           = is_last;
      r.hit_count      = hits_m;
      r.miss_count     = misses_m;
      r.eviction_count = evicts_m;
   endtask

   // A fetch gives nothing, a modify is a load then a store to the same
   // address, and loads and stores give one response each.
   task automatic predict_item(input slru_req_type q, output slru_rsp_type r0,
                               output slru_rsp_type r1, output int cnt);
      r0  = '0;
      r1  = '0;
      cnt = 0;
      if (q.kind == KIND_MODIFY) begin
         cache_access(q.address, 1'b0, r0);
         cache_access(q.address, 1'b1, r1);
         cnt = 2;
      end else if (q.kind != KIND_FETCH) begin
         cache_access(q.address, 1'b1, r0);
         cnt = 1;
      end
   endtask

   // Present one request and hold it until the transfer takes place. The
   // model is advanced at the transfer; a typed row supplies its own
   // expectations in place of the model's.
   task automatic send_access(input slru_req_type q, input bit typed,
                              input int n_typed, input slru_rsp_type t0,
                              input slru_rsp_type t1);
      slru_rsp_type p0;
      slru_rsp_type p1;
      int           n;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      predict_item(q, p0, p1, n);
      if (typed) begin
         if (n_typed > 0) rsp_due.push_back(t0);
         if (n_typed > 1) rsp_due.push_back(t1);
      end else begin
         if (n > 0) rsp_due.push_back(p0);
         if (n > 1) rsp_due.push_back(p1);
      end
   endtask

   // Mostly short pauses, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   task automatic pause_sender();
      int g;
      g = 0;
      if (!calm && $urandom_range(0, 99) >= 55) g = idle_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every expected response has been seen,
   // then let the block settle so that it is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
   endtask

   // Write the three geometry registers and the spare index, one per clock.
   // The unused high bits of the write data carry noise, which the block
   // must drop.
   task automatic write_geometry(input logic [2:0] sb_val, input logic [5:0] bb_val,
                                 input logic [3:0] nw_val);
      csr_we    <= 1'b1;
      csr_index <= CSR_SET_BITS;
      csr_wdata <= {3'($urandom), sb_val};
      @(posedge clock);
      cfg_sb = sb_val;
      csr_index <= CSR_BLOCK_BITS;
      csr_wdata <= bb_val;
      @(posedge clock);
      cfg_bb = bb_val;
      csr_index <= CSR_WAYS_USED;
      csr_wdata <= {2'($urandom), nw_val};
      @(posedge clock);
      cfg_nw = nw_val;
      csr_index <= CSR_SPARE;
      csr_wdata <= 6'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return KIND_LOAD;
      if (r < 60) return KIND_STORE;
      if (r < 85) return KIND_MODIFY;
      return KIND_FETCH;
   endfunction

   // Most addresses are built from a small pool of tags in a few sets, so
   // that sets fill up, hit and evict. Some are replays of recent addresses,
   // and the rest are noise across all 64 bits.
   function automatic logic [63:0] pick_address();
      int          r;
      int          sb;
      int          bb;
      logic [63:0] a;
      logic [63:0] tag;
      logic [63:0] setv;
      logic [63:0] off;
      sb = eff_sb();
      bb = eff_bb();
      r  = $urandom_range(0, 99);
      if (r < 15 && recent_addr.size() > 0) begin
         a = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
      end else if (r < 30) begin
         a = {$urandom, $urandom};
      end else begin
         if (r < 38) tag = {$urandom, $urandom};
         else tag = 64'($urandom_range(0, eff_nw() + 3));
         if (r < 45) setv = 64'($urandom_range(0, SETS - 1));
         else setv = 64'($urandom_range(0, 3));
         setv = setv & ((64'd1 << sb) - 64'd1);
         off  = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
         a    = (tag << (bb + sb)) | (setv << bb) | off;
      end
      recent_addr.push_back(a);
      if (recent_addr.size() > 16) void'(recent_addr.pop_front());
      return a;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Response side: every transfer is compared with the oldest expectation,
   // and the ready line stalls at random.
   always @(posedge clock) begin
      slru_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $error("response transfer with no request waiting for it");
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            check_field("was_hit", 64'(want.was_hit), 64'(rsp_data.was_hit));
            check_field("evicted", 64'(want.evicted), 64'(rsp_data.evicted));
            check_field("last", 64'(want.last), 64'(rsp_data.last));
            check_field("hit_count", 64'(want.hit_count), 64'(rsp_data.hit_count));
            check_field("miss_count", 64'(want.miss_count),
                        64'(rsp_data.miss_count));
            check_field("eviction_count", 64'(want.eviction_count),
                        64'(rsp_data.eviction_count));
         end
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (calm || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         rsp_hold = idle_len() - 1;
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int unsigned  p;
      int unsigned  k;
      int unsigned  done;
      slru_req_type q;
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < $size(PROBES); k++) begin
         q.kind    = PROBES[k].kind;
         q.address = PROBES[k].address;
         send_access(q, PROBES[k].typed, int'(PROBES[k].n_typed), PROBES[k].r0,
                     PROBES[k].r1);
         pause_sender();
      end

      for (p = 0; p < N_PHASES; p++) begin
         // The geometry may only change while the block is idle.
         if (p > 0) begin
            drain();
            if (PH_SB[p] < 0) begin
               write_geometry(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                              4'($urandom_range(0, 15)));
            end else begin
               write_geometry(3'(PH_SB[p]), 6'(PH_BB[p]), 4'(PH_NW[p]));
            end
         end
         calm = (p % 3 == 2);
         done = 0;
         while (done < PH_ITEMS[p]) begin
            q.kind    = pick_kind();
            q.address = pick_address();
            send_access(q, 1'b0, 0, NO_RSP, NO_RSP);
            done++;
            // Halfway through the first phase the sender holds back until
            // the block has handed over every response it owes.
            if (p == 0 && done == PH_ITEMS[0] / 2) drain();
            pause_sender();
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
